// ----- rtl/tps_pkg.sv -----
// Package for the triangle plane setup block: widths, latencies, codes and
// the word types shared by the top level, the unit-vector pipeline and the checker.
// No dependencies.
package tps_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int EW          = CW + 1;              // edge component
  localparam int PW          = 2 * EW;              // product of an edge-sized pair
  localparam int XW          = PW + 1;              // cross product component
  localparam int LW          = $clog2(XW + 1);      // bit length of a magnitude
  localparam int MW          = 31;                  // normalized magnitude
  localparam int SQW         = 2 * MW;
  localparam int SUMW        = 64;
  localparam int SQRT_STEPS  = SUMW / 2;
  localparam int LENW        = SQRT_STEPS;
  localparam int FRAC        = 30;
  localparam int NUMW        = MW + FRAC + 1;
  localparam int QW          = 31;
  localparam int DIV_STEPS   = QW;
  localparam int NW          = 32;                  // Q1.30 component and Q16.16 offset
  localparam int DW          = NW + CW;             // dot product term
  localparam int SW          = DW + 2;              // dot product sum
  localparam int SHW         = SW - FRAC;           // dot product sum after rounding shift
  localparam int NPLANE      = 4;
  localparam int ULAT        = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  typedef enum logic [1:0] {
    SEL_TRI   = 2'd0,
    SEL_EDGE1 = 2'd1,
    SEL_EDGE2 = 2'd2,
    SEL_EDGE3 = 2'd3
  } sel_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [XW-1:0] wide_t;
  typedef logic signed [NW-1:0] comp_t;

  typedef struct packed { coord_t x; coord_t y; coord_t z; } vert_t;
  typedef struct packed { edge_t x;  edge_t y;  edge_t z;  } evec_t;
  typedef struct packed { wide_t x;  wide_t y;  wide_t z;  } wvec_t;
  typedef struct packed { comp_t x;  comp_t y;  comp_t z;  } nvec_t;
  typedef struct packed { vert_t a;  vert_t b;  vert_t c;  } tri_t;

  typedef struct packed {
    logic  valid;
    wvec_t v;
  } unit_req_t;

  typedef struct packed {
    logic  valid;
    logic  deg;
    nvec_t n;
  } unit_res_t;

  typedef struct packed {
    sel_t  sel;
    nvec_t n;
    vert_t pt;
    logic  deg;
  } side_t;

endpackage

// ----- rtl/tps_unitize.sv -----
// Unit-vector pipeline: scales an exact cross product to a Q1.30 unit vector.
// Magnitude, normalize, square, sum, bit-per-stage square root, bit-per-stage division, sign.
// Depends on tps_pkg.
module tps_unitize import tps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  unit_req_t req,
  output unit_res_t res
);

  logic [ULAT-1:0] vld;

  wide_t           comp_in [3];
  logic [XW-1:0]   amag [3];
  logic [2:0]      aneg;
  logic [XW-1:0]   bmag [3];
  logic [2:0]      bneg;
  logic [LW-1:0]   blen;
  logic [LW-1:0]   blen_next;
  logic [MW-1:0]   cm [3];
  logic [MW-1:0]   cm_next [3];
  logic [2:0]      cneg;
  logic            czero;
  logic [SQW-1:0]  dsq [3];
  logic [MW-1:0]   dm [3];
  logic [2:0]      dneg;
  logic            dzero;

  logic [SUMW-1:0] sx [SQRT_STEPS+1];
  logic [SUMW-1:0] sr [SQRT_STEPS+1];
  logic [MW-1:0]   sm [SQRT_STEPS+1][3];
  logic [2:0]      sneg [SQRT_STEPS+1];
  logic            szero [SQRT_STEPS+1];

  logic [LENW-1:0] qrem [DIV_STEPS+1][3];
  logic [QW-1:0]   qlow [DIV_STEPS+1][3];
  logic [QW-1:0]   qq [DIV_STEPS+1][3];
  logic [LENW-1:0] qlen [DIV_STEPS+1];
  logic [2:0]      qneg [DIV_STEPS+1];
  logic            qzero [DIV_STEPS+1];

  nvec_t           rn;
  logic            rdeg;

  function automatic logic [2*SUMW-1:0] sqrt_step(logic [SUMW-1:0] x, logic [SUMW-1:0] r,
                                                  int s);
    logic [SUMW-1:0] b;
    logic [SUMW-1:0] t;
    b = SUMW'(1) << (SUMW - 2 * s);
    t = r + b;
    if (x >= t) begin
      return {x - t, (r >> 1) + b};
    end
    return {x, r >> 1};
  endfunction

  function automatic logic [LENW+QW-1:0] div_step(logic [LENW-1:0] rem, logic nb,
                                                 logic [QW-1:0] q, logic [LENW-1:0] len);
    logic [LENW:0] t;
    t = {rem, nb};
    if (t >= {1'b0, len}) begin
      t = t - {1'b0, len};
      return {t[LENW-1:0], q[QW-2:0], 1'b1};
    end
    return {t[LENW-1:0], q[QW-2:0], 1'b0};
  endfunction

  always_comb begin
    comp_in[0] = req.v.x;
    comp_in[1] = req.v.y;
    comp_in[2] = req.v.z;
  end

  always_comb begin
    logic [XW-1:0] orv;
    orv = amag[0] | amag[1] | amag[2];
    blen_next = '0;
    for (int j = 0; j < XW; j++) begin
      if (orv[j]) blen_next = LW'(j + 1);
    end
  end

  always_comb begin
    logic [XW-1:0] shv;
    for (int i = 0; i < 3; i++) begin
      if (blen > LW'(MW)) begin
        shv = bmag[i] >> (blen - LW'(MW));
      end else begin
        shv = bmag[i] << (LW'(MW) - blen);
      end
      cm_next[i] = shv[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ULAT-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [NUMW-1:0] num;
    logic [LENW-1:0] len;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        aneg[i] <= comp_in[i][XW-1];
        amag[i] <= comp_in[i][XW-1] ? XW'(-comp_in[i]) : XW'(comp_in[i]);
        bmag[i] <= amag[i];
        cm[i]   <= cm_next[i];
        dsq[i]  <= SQW'(cm[i]) * SQW'(cm[i]);
        dm[i]   <= cm[i];
        sm[0][i] <= dm[i];
      end
      bneg  <= aneg;
      blen  <= blen_next;
      cneg  <= bneg;
      czero <= (blen == '0);
      dneg  <= cneg;
      dzero <= czero;

      sx[0]    <= SUMW'(dsq[0]) + SUMW'(dsq[1]) + SUMW'(dsq[2]);
      sr[0]    <= '0;
      sneg[0]  <= dneg;
      szero[0] <= dzero;
      for (int s = 1; s <= SQRT_STEPS; s++) begin
        {sx[s], sr[s]} <= sqrt_step(sx[s-1], sr[s-1], s);
        sneg[s]  <= sneg[s-1];
        szero[s] <= szero[s-1];
        for (int i = 0; i < 3; i++) sm[s][i] <= sm[s-1][i];
      end

      len = sr[SQRT_STEPS][LENW-1:0];
      for (int i = 0; i < 3; i++) begin
        num = NUMW'({sm[SQRT_STEPS][i], FRAC'(0)}) + NUMW'(len >> 1);
        qrem[0][i] <= LENW'(num[NUMW-1:QW]);
        qlow[0][i] <= num[QW-1:0];
        qq[0][i]   <= '0;
      end
      qlen[0]  <= len;
      qneg[0]  <= sneg[SQRT_STEPS];
      qzero[0] <= szero[SQRT_STEPS];
      for (int s = 1; s <= DIV_STEPS; s++) begin
        for (int i = 0; i < 3; i++) begin
          {qrem[s][i], qq[s][i]} <= div_step(qrem[s-1][i], qlow[s-1][i][QW-1],
                                              qq[s-1][i], qlen[s-1]);
          qlow[s][i] <= {qlow[s-1][i][QW-2:0], 1'b0};
        end
        qlen[s]  <= qlen[s-1];
        qneg[s]  <= qneg[s-1];
        qzero[s] <= qzero[s-1];
      end

      rdeg <= qzero[DIV_STEPS];
      rn.x <= qzero[DIV_STEPS] ? '0 : qneg[DIV_STEPS][0] ? -NW'(qq[DIV_STEPS][0])
                                                         : NW'(qq[DIV_STEPS][0]);
      rn.y <= qzero[DIV_STEPS] ? '0 : qneg[DIV_STEPS][1] ? -NW'(qq[DIV_STEPS][1])
                                                         : NW'(qq[DIV_STEPS][1]);
      rn.z <= qzero[DIV_STEPS] ? '0 : qneg[DIV_STEPS][2] ? -NW'(qq[DIV_STEPS][2])
                                                         : NW'(qq[DIV_STEPS][2]);
    end
  end

  always_comb begin
    res.valid = vld[ULAT-1];
    res.deg   = rdeg;
    res.n     = rn;
  end

endmodule

// ----- rtl/triangle_plane_setup.sv -----
// Top level of the triangle plane setup block: triangle in, four planes out.
// Depends on tps_pkg and tps_unitize.
//
//   channel  | handshake              | word
//   ---------+------------------------+--------------------------------------------
//   triangle | tri_valid / tri_stall  | ax ay az bx by bz cx cy cz (Q16.16)
//   plane    | plane_valid/plane_stall| plane_nx/ny/nz, plane_offset, plane_select,
//            |                        | last, degenerate
//
// Triangles enter spaced to match their four plane words; one plane word per cycle while
// plane_stall is low, set by the single plane output. Each of the two unit-vector
// pipelines is 70 stages (32 root steps, 31 quotient steps).
// Reset clears all valid bits. A stalled plane word freezes every stage; one
// triangle still fits in the input buffer during a stall.
module triangle_plane_setup import tps_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          tri_valid,
  output logic          tri_stall,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] az,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  input  logic signed [CW-1:0] bz,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] cz,
  output logic          plane_valid,
  input  logic          plane_stall,
  output logic signed [NW-1:0] plane_nx,
  output logic signed [NW-1:0] plane_ny,
  output logic signed [NW-1:0] plane_nz,
  output logic signed [NW-1:0] plane_offset,
  output logic [1:0]    plane_select,
  output logic          last,
  output logic          degenerate
);

  logic en;
  logic inject;
  logic accept;
  logic in_full;
  tri_t in_tri;
  logic [1:0] gap;

  logic s1v, s2v, s3v, s4v;
  tri_t s1t, s2t, s3t, s4t;
  evec_t s2e1, s2e2;
  logic signed [PW-1:0] s3p [6];
  wvec_t s4w;

  unit_req_t ua_req;
  unit_res_t ua;
  tri_t tdl [ULAT];

  sel_t cnt;
  nvec_t hn;
  logic hdeg;
  tri_t ht;
  evec_t he [3];

  logic p0v, p0v_next;
  side_t p0s, p0s_next;
  evec_t p0e, p0e_next;
  logic p1v, p2v;
  side_t p1s, p2s;
  logic signed [PW-1:0] p1p [6];
  wvec_t p2w;

  unit_req_t ub_req;
  unit_res_t ub;
  side_t sdl [ULAT];

  logic q1v, q2v, q3v;
  side_t q1s;
  sel_t q2sel, q3sel;
  nvec_t q2n, q3n;
  logic q2deg, q3deg;
  logic signed [DW-1:0] q2d [3];
  logic signed [SW-1:0] q3sum;
  logic signed [SHW-1:0] shv;

  function automatic evec_t edge_of(vert_t p, vert_t q);
    evec_t e;
    e.x = edge_t'(q.x) - edge_t'(p.x);
    e.y = edge_t'(q.y) - edge_t'(p.y);
    e.z = edge_t'(q.z) - edge_t'(p.z);
    return e;
  endfunction

  function automatic logic signed [PW-1:0] mul_ee(edge_t a, edge_t b);
    logic signed [PW-1:0] wa;
    logic signed [PW-1:0] wb;
    wa = PW'(a);
    wb = PW'(b);
    return wa * wb;
  endfunction

  function automatic logic signed [PW-1:0] mul_ne(comp_t a, edge_t b);
    logic signed [PW-1:0] wa;
    logic signed [PW-1:0] wb;
    wa = PW'(a);
    wb = PW'(b);
    return wa * wb;
  endfunction

  function automatic logic signed [DW-1:0] mul_nc(comp_t a, coord_t b);
    logic signed [DW-1:0] wa;
    logic signed [DW-1:0] wb;
    wa = DW'(a);
    wb = DW'(b);
    return wa * wb;
  endfunction

  assign en     = !(plane_valid && plane_stall);
  assign inject = en && in_full && (gap == 2'd0);
  assign tri_stall = in_full && !inject;
  assign accept = tri_valid && !tri_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      gap     <= 2'd0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (inject) begin
        in_full <= 1'b0;
      end
      if (inject) begin
        gap <= 2'(NPLANE - 1);
      end else if (en && gap != 2'd0) begin
        gap <= gap - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_tri <= {ax, ay, az, bx, by, bz, cx, cy, cz};
  end

  // triangle normal front end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
    end else if (en) begin
      s1v <= inject;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1t  <= in_tri;
      s2t  <= s1t;
      s2e1 <= edge_of(s1t.a, s1t.b);
      s2e2 <= edge_of(s1t.b, s1t.c);
      s3t  <= s2t;
      s3p[0] <= mul_ee(s2e1.y, s2e2.z);
      s3p[1] <= mul_ee(s2e1.z, s2e2.y);
      s3p[2] <= mul_ee(s2e1.z, s2e2.x);
      s3p[3] <= mul_ee(s2e1.x, s2e2.z);
      s3p[4] <= mul_ee(s2e1.x, s2e2.y);
      s3p[5] <= mul_ee(s2e1.y, s2e2.x);
      s4t  <= s3t;
      s4w.x <= wide_t'(s3p[0]) - wide_t'(s3p[1]);
      s4w.y <= wide_t'(s3p[2]) - wide_t'(s3p[3]);
      s4w.z <= wide_t'(s3p[4]) - wide_t'(s3p[5]);
    end
  end

  assign ua_req.valid = s4v;
  assign ua_req.v     = s4w;

  tps_unitize u_unit_tri (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (ua_req),
    .res (ua)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tdl[0] <= s4t;
      for (int i = 1; i < ULAT; i++) tdl[i] <= tdl[i-1];
    end
  end

  // plane sequencer: triangle plane first, then the edge planes in order (SEL_EDGE1 to SEL_EDGE3)
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= SEL_TRI;
    end else if (en) begin
      if (ua.valid) begin
        cnt <= SEL_EDGE1;
      end else begin
        case (cnt)
          SEL_EDGE1: cnt <= SEL_EDGE2;
          SEL_EDGE2: cnt <= SEL_EDGE3;
          default:   cnt <= SEL_TRI;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ua.valid) begin
      hn    <= ua.n;
      hdeg  <= ua.deg;
      ht    <= tdl[ULAT-1];
      he[0] <= edge_of(tdl[ULAT-1].a, tdl[ULAT-1].b);
      he[1] <= edge_of(tdl[ULAT-1].b, tdl[ULAT-1].c);
      he[2] <= edge_of(tdl[ULAT-1].c, tdl[ULAT-1].a);
    end
  end

  always_comb begin
    p0v_next = ua.valid || (cnt != SEL_TRI);
    if (ua.valid) begin
      p0s_next.sel = SEL_TRI;
      p0s_next.n   = ua.n;
      p0s_next.pt  = tdl[ULAT-1].a;
      p0s_next.deg = ua.deg;
      p0e_next     = he[0];
    end else begin
      p0s_next.sel = cnt;
      p0s_next.n   = hn;
      p0s_next.deg = hdeg;
      case (cnt)
        SEL_EDGE1: begin
          p0s_next.pt = ht.a;
          p0e_next    = he[0];
        end
        SEL_EDGE2: begin
          p0s_next.pt = ht.b;
          p0e_next    = he[1];
        end
        default: begin
          p0s_next.pt = ht.c;
          p0e_next    = he[2];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0v <= 1'b0;
      p1v <= 1'b0;
      p2v <= 1'b0;
    end else if (en) begin
      p0v <= p0v_next;
      p1v <= p0v;
      p2v <= p1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0s <= p0s_next;
      p0e <= p0e_next;
      p1s <= p0s;
      p1p[0] <= mul_ne(p0s.n.y, p0e.z);
      p1p[1] <= mul_ne(p0s.n.z, p0e.y);
      p1p[2] <= mul_ne(p0s.n.z, p0e.x);
      p1p[3] <= mul_ne(p0s.n.x, p0e.z);
      p1p[4] <= mul_ne(p0s.n.x, p0e.y);
      p1p[5] <= mul_ne(p0s.n.y, p0e.x);
      p2s <= p1s;
      p2w.x <= wide_t'(p1p[0]) - wide_t'(p1p[1]);
      p2w.y <= wide_t'(p1p[2]) - wide_t'(p1p[3]);
      p2w.z <= wide_t'(p1p[4]) - wide_t'(p1p[5]);
    end
  end

  assign ub_req.valid = p2v;
  assign ub_req.v     = p2w;

  tps_unitize u_unit_edge (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (ub_req),
    .res (ub)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= p2s;
      for (int i = 1; i < ULAT; i++) sdl[i] <= sdl[i-1];
    end
  end

  // offset: dot with vertex, round, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      q1v <= 1'b0;
      q2v <= 1'b0;
      q3v <= 1'b0;
      plane_valid <= 1'b0;
    end else if (en) begin
      q1v <= ub.valid;
      q2v <= q1v;
      q3v <= q2v;
      plane_valid <= q3v;
    end
  end

  assign shv = q3sum[SW-1:FRAC];

  always_ff @(posedge clk) begin
    if (en) begin
      q1s.sel <= sdl[ULAT-1].sel;
      q1s.pt  <= sdl[ULAT-1].pt;
      q1s.n   <= (sdl[ULAT-1].sel == SEL_TRI) ? sdl[ULAT-1].n : ub.n;
      q1s.deg <= (sdl[ULAT-1].sel == SEL_TRI) ? sdl[ULAT-1].deg : ub.deg;
      q2sel <= q1s.sel;
      q2n   <= q1s.n;
      q2deg <= q1s.deg;
      q2d[0] <= mul_nc(q1s.n.x, q1s.pt.x);
      q2d[1] <= mul_nc(q1s.n.y, q1s.pt.y);
      q2d[2] <= mul_nc(q1s.n.z, q1s.pt.z);
      q3sel <= q2sel;
      q3n   <= q2n;
      q3deg <= q2deg;
      q3sum <= SW'(q2d[0]) + SW'(q2d[1]) + SW'(q2d[2]) + (SW'(1) << (FRAC - 1));
      plane_nx     <= q3n.x;
      plane_ny     <= q3n.y;
      plane_nz     <= q3n.z;
      plane_select <= q3sel;
      last         <= (q3sel == SEL_EDGE3);
      degenerate   <= q3deg;
      if ((&shv[SHW-1:NW-1]) || !(|shv[SHW-1:NW-1])) begin
        plane_offset <= shv[NW-1:0];
      end else if (shv[SHW-1]) begin
        plane_offset <= {1'b1, {(NW-1){1'b0}}};
      end else begin
        plane_offset <= {1'b0, {(NW-1){1'b1}}};
      end
    end
  end

endmodule

// ----- rtl/tps_checker.sv -----
// Port-level checks for triangle_plane_setup, bound to the top level.
// Depends on tps_pkg.
module tps_checker import tps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic plane_valid,
  input logic plane_stall,
  input logic signed [NW-1:0] plane_nx,
  input logic signed [NW-1:0] plane_ny,
  input logic signed [NW-1:0] plane_nz,
  input logic signed [NW-1:0] plane_offset,
  input logic [1:0] plane_select,
  input logic last,
  input logic degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    plane_valid && plane_stall |=> plane_valid &&
      $stable({plane_nx, plane_ny, plane_nz, plane_offset, plane_select, last, degenerate}))
    else $error("stalled plane word changed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    plane_valid && !plane_stall && plane_select != SEL_EDGE3 |=>
      plane_valid && plane_select == 2'($past(plane_select) + 2'd1))
    else $error("planes of a triangle not back to back in order");

  a_deg: assert property (@(posedge clk) disable iff (rst)
    plane_valid && !plane_stall && plane_select == SEL_TRI && degenerate |=> degenerate)
    else $error("degenerate triangle gave a non-degenerate edge plane");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    plane_valid && !degenerate |-> plane_nx != 0 || plane_ny != 0 || plane_nz != 0)
    else $error("zero normal without degenerate flag");

endmodule

bind triangle_plane_setup tps_checker u_tps_checker (.*);
